// ----- rtl/top_n_winner_assign_macros.svh -----
// assertion macros for the top n winner assign block
`ifndef TOP_N_WINNER_ASSIGN_MACROS_SVH
`define TOP_N_WINNER_ASSIGN_MACROS_SVH
`ifndef SYNTHESIS
`define TNWA_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define TNWA_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define TNWA_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define TNWA_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

// ----- rtl/tnwa_pkg.sv -----
// shared types and constants of the top n winner assign block
package tnwa_pkg;

  localparam int DataW   = 32;
  localparam int PosW    = 6;
  localparam int CountW  = 7;
  localparam int RegIdxW = 2;

  typedef enum logic [RegIdxW-1:0] {
    REG_WINNER_COUNT = 2'd0,
    REG_WINNER_VALUE = 2'd1,
    REG_LOSER_VALUE  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MARK = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic insert;
    logic clear;
  } chain_ctl_t;

  typedef struct packed {
    logic                    valid;
    logic [PosW-1:0]         pos;
    logic signed [DataW-1:0] value;
  } cell_t;

endpackage

// ----- rtl/tnwa_in_if.sv -----
// input channel: one vector element per transfer
interface tnwa_in_if import tnwa_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] sample;
  logic                    final_item;

  modport source (output valid, output sample, output final_item, input ready);
  modport sink (input valid, input sample, input final_item, output ready);
endinterface

// ----- rtl/tnwa_out_if.sv -----
// output channel: one result per loaded element
interface tnwa_out_if import tnwa_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [PosW-1:0]         position;
  logic                    is_winner;
  logic signed [DataW-1:0] assigned_value;
  logic                    end_of_run;

  modport source (output valid, output position, output is_winner,
                  output assigned_value, output end_of_run, input ready);
  modport sink (input valid, input position, input is_winner,
                input assigned_value, input end_of_run, output ready);
endinterface

// ----- rtl/tnwa_cell.sv -----
// one cell of the sorted insertion chain
module tnwa_cell import tnwa_pkg::*; #(
  parameter int Index = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  chain_ctl_t              ctl,
  input  logic signed [DataW-1:0] sample,
  input  logic [PosW-1:0]         sample_pos,
  input  cell_t                   prev,
  input  logic                    prev_gt,
  input  logic [CountW-1:0]       winner_count,
  output cell_t                   cur,
  output logic                    gt,
  output logic                    win
);

  logic                    valid;
  logic [PosW-1:0]         pos;
  logic signed [DataW-1:0] value;

  // empty cells rank below everything
  assign gt  = !valid || (sample > value);
  assign win = valid && (winner_count > CountW'(Index));
  assign cur = '{valid: valid, pos: pos, value: value};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.insert) begin
      if (prev_gt) begin
        valid <= prev.valid;
      end else if (gt) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (prev_gt) begin
        pos   <= prev.pos;
        value <= prev.value;
      end else if (gt) begin
        pos   <= sample_pos;
        value <= sample;
      end
    end
  end

endmodule

// ----- rtl/tnwa_chain.sv -----
// row of insertion cells and the winner mask by position
module tnwa_chain import tnwa_pkg::*; #(
  parameter int MaxLen = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  chain_ctl_t              ctl,
  input  logic signed [DataW-1:0] sample,
  input  logic [PosW-1:0]         sample_pos,
  input  logic [CountW-1:0]       winner_count,
  output logic [MaxLen-1:0]       mask,
  output logic [MaxLen-1:0]       valid_vec
);

  cell_t       cells [MaxLen];
  logic [MaxLen-1:0] gt;
  logic [MaxLen-1:0] win;

  for (genvar i = 0; i < MaxLen; i++) begin : g_cell
    cell_t prev;
    logic  prev_gt;
    if (i == 0) begin : g_head
      assign prev    = '0;
      assign prev_gt = 1'b0;
    end else begin : g_body
      assign prev    = cells[i-1];
      assign prev_gt = gt[i-1];
    end
    tnwa_cell #(.Index(i)) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .sample       (sample),
      .sample_pos   (sample_pos),
      .prev         (prev),
      .prev_gt      (prev_gt),
      .winner_count (winner_count),
      .cur          (cells[i]),
      .gt           (gt[i]),
      .win          (win[i])
    );
    assign valid_vec[i] = cells[i].valid;
  end

  always_comb begin
    mask = '0;
    for (int p = 0; p < MaxLen; p++) begin
      for (int i = 0; i < MaxLen; i++) begin
        if (win[i] && (cells[i].pos == PosW'(p))) begin
          mask[p] = 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/top_n_winner_assign.sv -----
// top level of the top n winner assign block
// Streams in up to MaxLen signed Q16.16 samples, one per cycle, into a row of
// insertion cells that keeps them sorted in descending order with their
// positions (earlier position wins ties, samples past MaxLen are dropped).
// After the final sample the block builds the winner mask from the first
// winner_count cells and clears the row in the mask state, then sends one
// result per loaded element in position order, one per cycle while the sink
// takes them; input is held off from the mask cycle until the last result is
// loaded into the output register.
`include "top_n_winner_assign_macros.svh"

module top_n_winner_assign import tnwa_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic               clk,
  input  logic               rst,
  tnwa_in_if.sink            samples,
  tnwa_out_if.source         results,
  input  logic               write_enable,
  input  logic [RegIdxW-1:0] reg_index,
  input  logic [DataW-1:0]   write_data
);

  localparam int CntW = $clog2(MAX_LEN + 1);
  localparam int IdxW = $clog2(MAX_LEN);

  state_t                  state;
  logic [CntW-1:0]         loaded_count;
  logic [IdxW-1:0]         emit_idx;
  logic [MAX_LEN-1:0]      winner_mask;
  logic [MAX_LEN-1:0]      mask;
  logic [MAX_LEN-1:0]      valid_vec;
  logic [CountW-1:0]       winner_count;
  logic signed [DataW-1:0] winner_value;
  logic signed [DataW-1:0] loser_value;
  logic                    out_valid;
  logic [PosW-1:0]         out_position;
  logic                    out_winner;
  logic signed [DataW-1:0] out_value;
  logic                    out_end;
  chain_ctl_t              ctl;
  logic                    in_xfer;
  logic                    final_xfer;
  logic                    full;
  logic                    emit_load;
  logic                    emit_last;
  logic                    fill_ok;

  assign samples.ready = (state == S_IDLE);
  assign in_xfer       = samples.valid && samples.ready;
  assign final_xfer    = in_xfer && samples.final_item;
  assign full          = (loaded_count == CntW'(MAX_LEN));
  assign ctl.insert    = in_xfer && !full;
  assign ctl.clear     = (state == S_MARK);
  assign emit_load     = (state == S_EMIT) && (!out_valid || results.ready);
  assign emit_last     = (CntW'(emit_idx) + CntW'(1)) == loaded_count;
  assign fill_ok       = ($countones(valid_vec) == int'(loaded_count));

  tnwa_chain #(.MaxLen(MAX_LEN)) u_chain (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sample       (samples.sample),
    .sample_pos   (PosW'(loaded_count)),
    .winner_count (winner_count),
    .mask         (mask),
    .valid_vec    (valid_vec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      winner_count <= CountW'(1);
      winner_value <= DataW'(65536);
      loser_value  <= '0;
    end else if (write_enable) begin
      unique case (reg_idx_t'(reg_index))
        REG_WINNER_COUNT: winner_count <= write_data[CountW-1:0];
        REG_WINNER_VALUE: winner_value <= write_data;
        REG_LOSER_VALUE:  loser_value  <= write_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      loaded_count <= '0;
      emit_idx     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (ctl.insert) begin
            loaded_count <= loaded_count + CntW'(1);
          end
          if (final_xfer) begin
            state <= S_MARK;
          end
        end
        S_MARK: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_load) begin
            if (emit_last) begin
              state        <= S_IDLE;
              loaded_count <= '0;
              emit_idx     <= '0;
            end else begin
              emit_idx <= emit_idx + IdxW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MARK) begin
      winner_mask <= mask;
    end
    if (emit_load) begin
      out_position <= PosW'(emit_idx);
      out_winner   <= winner_mask[emit_idx];
      out_value    <= winner_mask[emit_idx] ? winner_value : loser_value;
      out_end      <= emit_last;
    end
  end

  assign results.valid          = out_valid;
  assign results.position       = out_position;
  assign results.is_winner      = out_winner;
  assign results.assigned_value = out_value;
  assign results.end_of_run     = out_end;

  `TNWA_ASSERT(a_fill_count, clk, rst, (state == S_IDLE) |-> fill_ok, "fill differs from count")
  `TNWA_ASSERT_ALWAYS(a_mark_clears, clk, state == S_MARK |=> valid_vec == '0, "row not cleared")
  `TNWA_ASSERT(a_final_mark, clk, rst, final_xfer |=> state == S_MARK, "no mask cycle")

endmodule

// ----- tb/tb_top_n_winner_assign.sv -----
// self-checking testbench for the top n winner assign block
module tb_top_n_winner_assign;
  import tnwa_pkg::*;

  localparam int MaxLen = 64;
  localparam int RandomItems = 100;
  localparam int LatencyPad = 4;
  localparam int CycleLimit = 100000;
  localparam logic [RegIdxW-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [PosW-1:0]         position;
    logic                    is_winner;
    logic signed [DataW-1:0] assigned_value;
    logic                    end_of_run;
  } mark_t;

  class winner_board;
    int count = 1;
    logic signed [DataW-1:0] win_level = 32'sd65536;
    logic signed [DataW-1:0] lose_level = 32'sd0;
    logic signed [DataW-1:0] run_samples[$];
    mark_t expected_marks[$];
    int errors = 0;
    int checked = 0;
    int runs = 0;
    int dropped = 0;

    function void set_reg(logic [RegIdxW-1:0] idx, logic [DataW-1:0] data);
      if (idx == REG_WINNER_COUNT) count = int'(data[CountW-1:0]);
      else if (idx == REG_WINNER_VALUE) win_level = data;
      else if (idx == REG_LOSER_VALUE) lose_level = data;
    endfunction

    // rank each element against all others; earlier position wins ties
    function void note_sample(logic signed [DataW-1:0] v, logic last);
      int n;
      int k;
      int ahead;
      mark_t m;
      if (run_samples.size() < MaxLen) run_samples.push_back(v);
      else dropped++;
      if (!last) return;
      n = run_samples.size();
      k = (count < n) ? count : n;
      for (int i = 0; i < n; i++) begin
        ahead = 0;
        for (int j = 0; j < n; j++)
          if (run_samples[j] > run_samples[i] || (run_samples[j] == run_samples[i] && j < i))
            ahead++;
        m.position = PosW'(i);
        m.is_winner = (ahead < k);
        m.assigned_value = m.is_winner ? win_level : lose_level;
        m.end_of_run = (i == n - 1);
        expected_marks.push_back(m);
      end
      run_samples.delete();
      runs++;
    endfunction

    function void check_result(mark_t got);
      mark_t want;
      if (expected_marks.size() == 0) begin
        $display("%0t: unexpected result pos %0d win %0b value %0d last %0b", $time,
                 got.position, got.is_winner, got.assigned_value, got.end_of_run);
        errors++;
        return;
      end
      want = expected_marks.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: mismatch expected pos %0d win %0b value %0d last %0b", $time,
                 want.position, want.is_winner, want.assigned_value, want.end_of_run);
        $display("%0t:          actual   pos %0d win %0b value %0d last %0b", $time,
                 got.position, got.is_winner, got.assigned_value, got.end_of_run);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_marks.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic write_enable;
  logic [RegIdxW-1:0] reg_index;
  logic [DataW-1:0] write_data;
  bit no_gaps;
  int sink_hold;
  int cycles = 0;
  winner_board board = new;

  tnwa_in_if samples_if();
  tnwa_out_if results_if();

  top_n_winner_assign #(.MAX_LEN(MaxLen)) dut (
    .clk(clk),
    .rst(rst),
    .samples(samples_if),
    .results(results_if),
    .write_enable(write_enable),
    .reg_index(reg_index),
    .write_data(write_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        board.check_result({results_if.position, results_if.is_winner,
                            results_if.assigned_value, results_if.end_of_run});
        sink_hold = no_gaps ? 0 : $urandom_range(0, 3);
      end else if (sink_hold > 0) begin
        sink_hold = sink_hold - 1;
      end
      results_if.ready <= (sink_hold == 0);
    end
  end

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] data);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= data;
    @(posedge clk);
    board.set_reg(idx, data);
  endtask

  task automatic configure(input int count, input logic [DataW-1:0] win_level,
                           input logic [DataW-1:0] lose_level);
    write_reg(REG_WINNER_COUNT, DataW'(count));
    write_reg(REG_WINNER_VALUE, win_level);
    write_reg(REG_LOSER_VALUE, lose_level);
    write_enable <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [DataW-1:0] v, input logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid <= 1'b1;
    samples_if.sample <= v;
    samples_if.final_item <= last;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    board.note_sample(v, last);
  endtask

  task automatic wait_idle();
    samples_if.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (LatencyPad) @(posedge clk);
  endtask

  function automatic logic signed [DataW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3, 4: return ($signed($urandom_range(0, 4)) - 2) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_count();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 64;
      2: return 127;
      3: return $urandom_range(1, 3);
      default: return $urandom_range(0, 64);
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_level();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int random_items;
    int phase;
    int len;
    bit long_done;
    rst = 1'b1;
    no_gaps = 1'b0;
    write_enable = 1'b0;
    reg_index = '0;
    write_data = '0;
    samples_if.valid = 1'b0;
    samples_if.sample = '0;
    samples_if.final_item = 1'b0;
    random_items = 0;
    phase = 0;
    long_done = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: single element, extremes, equal values
    send_sample(32'sh8000_0000, 1'b1);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh0, 1'b0);
    send_sample(32'sd100, 1'b0);
    send_sample(32'sd100, 1'b0);
    send_sample(32'sd100, 1'b1);
    wait_idle();

    // zero count, plus a write to an unused index
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    configure(0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'sd5, 1'b0);
    send_sample(32'sd6, 1'b0);
    send_sample(32'sd7, 1'b0);
    send_sample(32'sd8, 1'b1);
    wait_idle();

    configure(2, 32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'sd7, 1'b0);
    send_sample(32'sd7, 1'b0);
    send_sample(32'sd7, 1'b0);
    send_sample(-32'sd1, 1'b1);
    wait_idle();

    configure(64, 32'hFFFF_FFFF, 32'h0001_8000);
    send_sample(32'sd3, 1'b0);
    send_sample(-32'sd3, 1'b0);
    send_sample(32'sd0, 1'b1);
    wait_idle();

    configure(127, 32'h0000_0001, 32'hFFFF_0000);
    send_sample(-32'sd1, 1'b0);
    send_sample(-32'sd1, 1'b1);
    wait_idle();

    while (random_items < RandomItems) begin
      no_gaps = (phase % 4 == 3);
      if (phase % 3 == 0) write_reg(REG_UNUSED, $urandom);
      configure(pick_count(), pick_level(), pick_level());
      repeat ($urandom_range(2, 4)) begin
        if (phase == 1 && !long_done) begin
          len = MaxLen + 2;
          long_done = 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
          len = $urandom_range(9, 16);
        end else begin
          len = $urandom_range(1, 8);
        end
        for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
        random_items += len;
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("covered %0d vectors over %0d random phases, %0d samples past capacity",
             board.runs, phase, board.dropped);
    $display("checked %0d results, %0d errors", board.checked, board.errors);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/tnwa_pkg.sv
rtl/tnwa_in_if.sv
rtl/tnwa_out_if.sv
rtl/tnwa_cell.sv
rtl/tnwa_chain.sv
rtl/top_n_winner_assign.sv
tb/tb_top_n_winner_assign.sv
